>>> rtl/mrfq_pkg.sv
// Shared constants, codes and types of the multi-row FIFO queue bank.
package mrfq_pkg;

  localparam int NUM_ROWS  = 4;
  localparam int ROW_DEPTH = 16;

  localparam int OP_W    = 1;
  localparam int ROW_IN_W = 2;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;

  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int PTR_W  = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(ROW_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_ROWS * ROW_DEPTH;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Access request from the pointer logic to the buffer memory.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

endpackage

>>> rtl/mrfq_if.sv
// Handshake channels for request and response words of the queue bank.
interface mrfq_req_if;
  logic                           valid;
  logic                           ready;
  logic [mrfq_pkg::OP_W-1:0]      operation;
  logic [mrfq_pkg::ROW_IN_W-1:0]  row;
  logic [mrfq_pkg::BYTE_W-1:0]    value;

  modport source (output valid, operation, row, value, input ready);
  modport sink   (input valid, operation, row, value, output ready);
endinterface

interface mrfq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mrfq_pkg::BYTE_W-1:0]  data_out;
  logic [mrfq_pkg::STAT_W-1:0]  status;

  modport source (output valid, data_out, status, input ready);
  modport sink   (input valid, data_out, status, output ready);
endinterface

>>> rtl/mrfq_ctrl.sv
// Per-row head, tail and fill registers; decides status and memory access.
module mrfq_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [mrfq_pkg::OP_W-1:0]      operation,
  input  logic [mrfq_pkg::ROW_IN_W-1:0]  row,
  input  logic [mrfq_pkg::BYTE_W-1:0]    value,
  output mrfq_pkg::mem_req_t             mem_req,
  output mrfq_pkg::status_t              status
);
  import mrfq_pkg::*;

  logic [PTR_W-1:0] head [NUM_ROWS];
  logic [PTR_W-1:0] tail [NUM_ROWS];
  logic [CNT_W-1:0] fill [NUM_ROWS];

  logic             row_ok;
  logic [ROW_W-1:0] rs;
  logic             enq_ok;
  logic             deq_ok;
  logic [PTR_W-1:0] ptr;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
    return (slot == PTR_W'(ROW_DEPTH - 1)) ? '0 : slot + PTR_W'(1);
  endfunction

  // Decode the word: row range, full and empty checks
  always_comb begin
    row_ok = (int'(row) < NUM_ROWS);
    rs     = ROW_W'(row);
    enq_ok = 1'b0;
    deq_ok = 1'b0;
    status = ST_OK;
    if (operation == OP_ENQ) begin
      if (!row_ok || fill[rs] == CNT_W'(ROW_DEPTH)) begin
        status = ST_FULL;
      end else begin
        enq_ok = 1'b1;
      end
    end else begin
      if (!row_ok || fill[rs] == '0) begin
        status = ST_EMPTY;
      end else begin
        deq_ok = 1'b1;
      end
    end
    ptr = (operation == OP_ENQ) ? tail[rs] : head[rs];
    mem_req.we    = accept && enq_ok;
    mem_req.re    = accept && deq_ok;
    mem_req.addr  = ADDR_W'(int'(rs) * ROW_DEPTH) + ADDR_W'(ptr);
    mem_req.wdata = value;
  end

  // Advance pointers and fill count of the addressed row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else if (mem_req.we) begin
      tail[rs] <= next_slot(tail[rs]);
      fill[rs] <= fill[rs] + CNT_W'(1);
    end else if (mem_req.re) begin
      head[rs] <= next_slot(head[rs]);
      fill[rs] <= fill[rs] - CNT_W'(1);
    end
  end

endmodule

>>> rtl/mrfq_store.sv
// Shared byte buffer memory for all rows, one access per cycle.
module mrfq_store (
  input  logic                         clk,
  input  mrfq_pkg::mem_req_t           mem_req,
  output logic [mrfq_pkg::BYTE_W-1:0]  rdata
);
  import mrfq_pkg::*;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];

  // Write on enqueue, register read data on dequeue and hold it otherwise
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.addr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rdata <= mem[mem_req.addr];
    end
  end

endmodule

>>> rtl/multi_row_fifo_queue_unit.sv
// A response word is valid in the cycle after its request word is accepted.
// Throughput: one word per cycle while responses are taken; the buffer memory port
// does one access per cycle; its registered read data feeds the response directly.
// A request is taken whenever the response register is empty or being drained.
// Reset (synchronous) empties every row and clears the response register;
// the buffer memory itself is not cleared.
module multi_row_fifo_queue_unit (
  input logic         clk,
  input logic         rst,
  mrfq_req_if.sink    req,
  mrfq_rsp_if.source  rsp
);
  import mrfq_pkg::*;

  logic              accept;
  mem_req_t          mem_req;
  status_t           status;
  logic [BYTE_W-1:0] rdata;
  logic              rsp_valid;
  status_t           rsp_status;
  logic              deq_hit;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  mrfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (req.operation),
    .row       (req.row),
    .value     (req.value),
    .mem_req   (mem_req),
    .status    (status)
  );

  mrfq_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  // Hold the response word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status;
      deq_hit    <= mem_req.re;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.data_out = deq_hit ? rdata : '0;

endmodule

>>> rtl/mrfq_checker.sv
// Port-level checks of the queue bank, bound to the top level.
module mrfq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [mrfq_pkg::BYTE_W-1:0]  rsp_data_out,
  input logic [mrfq_pkg::STAT_W-1:0]  rsp_status
);
  import mrfq_pkg::*;

  // Every accepted request gives a response word in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no response after accepted request");

  // Failed operations return zero data
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_data_out == '0)
    else $error("nonzero data with failure status");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_EMPTY ||
                   rsp_status == ST_FULL))
    else $error("undefined status code");

  // A stalled response word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status))
    else $error("stalled response changed");

endmodule

bind multi_row_fifo_queue_unit mrfq_checker u_mrfq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_data_out (rsp.data_out),
  .rsp_status   (rsp.status)
);

>>> tb/testbench.sv
// Self-checking testbench for the four-row byte FIFO bank: scoreboard, drivers and checks.
module testbench;
  import mrfq_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_WORDS = 1400;
  localparam int SHOW_LIMIT   = 10;

  typedef struct {
    logic [BYTE_W-1:0] data;
    status_t           status;
  } reply_t;

  // Shadow of the queue bank: predicts each reply and checks the replies in order.
  class queue_bank_scoreboard;
    logic [BYTE_W-1:0] slots [NUM_ROWS*ROW_DEPTH];
    int                head_slot [NUM_ROWS];
    int                tail_slot [NUM_ROWS];
    int                fill_level [NUM_ROWS];
    reply_t            expected_replies [$];
    int                failures;

    function void clear();
      for (int r = 0; r < NUM_ROWS; r++) begin
        head_slot[r]  = 0;
        tail_slot[r]  = 0;
        fill_level[r] = 0;
      end
      expected_replies.delete();
      failures = 0;
    endfunction

    // Apply one accepted request to the shadow rows and queue its reply.
    function void note_request(op_t op, logic [ROW_IN_W-1:0] row, logic [BYTE_W-1:0] value);
      int     r;
      reply_t want;
      r           = int'(row);
      want.data   = '0;
      want.status = ST_OK;
      if (op == OP_ENQ) begin
        if (r >= NUM_ROWS || fill_level[r] >= ROW_DEPTH) begin
          want.status = ST_FULL;
        end else begin
          slots[r*ROW_DEPTH + tail_slot[r]] = value;
          tail_slot[r]  = (tail_slot[r] + 1 >= ROW_DEPTH) ? 0 : tail_slot[r] + 1;
          fill_level[r] = fill_level[r] + 1;
        end
      end else begin
        if (r >= NUM_ROWS || fill_level[r] == 0) begin
          want.status = ST_EMPTY;
        end else begin
          want.data     = slots[r*ROW_DEPTH + head_slot[r]];
          head_slot[r]  = (head_slot[r] + 1 >= ROW_DEPTH) ? 0 : head_slot[r] + 1;
          fill_level[r] = fill_level[r] - 1;
        end
      end
      expected_replies.push_back(want);
    endfunction

    // Compare one accepted reply word with the oldest prediction.
    function void check_reply(logic [BYTE_W-1:0] data, logic [STAT_W-1:0] status);
      reply_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("tb: reply with none expected: data %02h status %0d", data, status);
        return;
      end
      want = expected_replies.pop_front();
      if (data !== want.data || status !== STAT_W'(want.status)) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("tb: reply mismatch: expected data %02h status %0d, got data %02h status %0d",
                   want.data, want.status, data, status);
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;

  mrfq_req_if req_ch ();
  mrfq_rsp_if rsp_ch ();

  queue_bank_scoreboard sb;

  multi_row_fifo_queue_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Watch both channels; a reply at this edge always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_reply(rsp_ch.data_out, rsp_ch.status);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(op_t'(req_ch.operation), req_ch.row, req_ch.value);
    end
  end

  // Receiver stall pattern: switch between steady, random, periodic and mostly-stalled modes.
  int stall_mode;
  int mode_left;
  int stall_period;
  int ready_duty;
  int pattern_pos;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode   = $urandom_range(0, 3);
      mode_left    = $urandom_range(20, 300);
      stall_period = $urandom_range(2, 8);
      ready_duty   = $urandom_range(1, stall_period - 1);
      pattern_pos  = 0;
    end
    mode_left   = mode_left - 1;
    pattern_pos = (pattern_pos + 1) % stall_period;
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= $urandom_range(0, 1);
      2: rsp_ch.ready <= (pattern_pos < ready_duty);
      default: rsp_ch.ready <= (pattern_pos == 0);
    endcase
  end

  // Present one request word and hold it until accepted.
  task automatic send_word(op_t op, logic [ROW_IN_W-1:0] row, logic [BYTE_W-1:0] value);
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.row       <= row;
    req_ch.value     <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic idle_words(int n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
  endtask

  // Hold off the sender until every predicted reply has come back.
  task automatic drain_replies();
    idle_words(1);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    // Dequeue from an empty row.
    send_word(OP_DEQ, 2'd0, 8'h00);
    // Extreme bytes through one row, then run it dry.
    send_word(OP_ENQ, 2'd1, 8'h00);
    send_word(OP_ENQ, 2'd1, 8'hFF);
    send_word(OP_DEQ, 2'd1, 8'hFF);
    send_word(OP_DEQ, 2'd1, 8'h00);
    send_word(OP_DEQ, 2'd1, 8'h00);
    // Fill a row to the top, then push into the full row.
    for (int i = 0; i < ROW_DEPTH; i++) send_word(OP_ENQ, 2'd2, 8'($urandom));
    send_word(OP_ENQ, 2'd2, 8'h5A);
    send_word(OP_DEQ, 2'd3, 8'hA5);
  endtask

  // Episodes with an enqueue bias and a favored row push rows to full and back to empty.
  task automatic run_random(int total);
    int left;
    int episode;
    int burst;
    int enq_pct;
    int focus_row;
    op_t op;
    logic [ROW_IN_W-1:0] row;
    left = total;
    while (left > 0) begin
      episode   = $urandom_range(40, 150);
      focus_row = $urandom_range(0, NUM_ROWS - 1);
      case ($urandom_range(0, 3))
        0: enq_pct = 20;
        1: enq_pct = 50;
        2: enq_pct = 80;
        default: enq_pct = 95;
      endcase
      if (episode > left) episode = left;
      left = left - episode;
      while (episode > 0) begin
        burst = $urandom_range(1, 40);
        if (burst > episode) burst = episode;
        episode = episode - burst;
        repeat (burst) begin
          op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
          row = ($urandom_range(0, 99) < 70) ? ROW_IN_W'(focus_row) : ROW_IN_W'($urandom);
          send_word(op, row, 8'($urandom));
        end
        if ($urandom_range(0, 3) != 0) idle_words($urandom_range(1, 8));
      end
      if ($urandom_range(0, 3) == 0) drain_replies();
    end
  endtask

  initial begin
    sb = new;
    sb.clear();
    cycles           = 0;
    mode_left        = 0;
    stall_period     = 2;
    pattern_pos      = 0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_ENQ;
    req_ch.row       = '0;
    req_ch.value     = '0;
    rsp_ch.ready     = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    run_directed();
    drain_replies();
    run_random(RANDOM_WORDS / 2);
    drain_replies();
    run_random(RANDOM_WORDS - RANDOM_WORDS / 2);
    drain_replies();
    repeat (5) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mrfq_pkg.sv
rtl/mrfq_if.sv
rtl/mrfq_ctrl.sv
rtl/mrfq_store.sv
rtl/multi_row_fifo_queue_unit.sv
rtl/mrfq_checker.sv
tb/testbench.sv
